>>> hw/rtl/robin_hood_id_set_macros.svh
// Assertion helpers for the RTL of the id set.
`ifndef ROBIN_HOOD_ID_SET_MACROS_SVH
`define ROBIN_HOOD_ID_SET_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RHIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RHIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rhis_pkg.sv
`default_nettype none
package rhis_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	localparam int W0_W    = 32;
	localparam int MID_W   = 64;
	localparam int TOP_W   = 64;
	localparam int DIST_W  = 10;
	localparam int COUNT_W = 11;
	localparam int SIZE_W  = 4;
	localparam int MAXE_W  = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [SIZE_W-1:0] SIZE_LOG2_RST   = 4'd10;
	localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 11'd877;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd1;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_DUP,
		STAT_FULL,
		STAT_NOSLOT
	} status_t;

	typedef struct packed {
		logic [W0_W-1:0]   w0;
		logic [MID_W-1:0]  mid;
		logic [TOP_W-1:0]  top;
		logic [DIST_W-1:0] pdist;
	} slot_t;

endpackage
`default_nettype wire

>>> hw/rtl/robin_hood_id_set.sv
`default_nettype none
// Set of 160-bit ids kept in one slot RAM with linear probing and Robin Hood
// displacement. A request is taken and its first read issued; then one slot
// after another is probed (none for an insert refused as full, else 1 up to
// the table size); then the result is handed to the output register, waiting
// while a previous result still waits there for out_ready. The probe loop is
// set by the single read port of the slot RAM, whose write port stores a
// displaced or new entry in the same cycle as the next slot is read. After
// reset a clearing pass writes every slot empty, during which no request is
// taken; configuration writes are taken at any time. An all-zero id is stored
// with its first word as 1.
module robin_hood_id_set #(
	parameter int TABLE_DEPTH = rhis_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [rhis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rhis_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             action,
	input  wire logic [rhis_pkg::W0_W-1:0]        id_word0,
	input  wire logic [rhis_pkg::MID_W-1:0]       id_mid,
	input  wire logic [rhis_pkg::TOP_W-1:0]       id_top,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  found,
	output logic [1:0]                            status,
	output logic [rhis_pkg::COUNT_W-1:0]          used_count
);
	import rhis_pkg::*;
	`include "robin_hood_id_set_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);

	state_t               state_q, state_nxt;
	logic [SIZE_W-1:0]    size_log2_q;
	logic [MAXE_W-1:0]    max_entries_q;
	logic [COUNT_W-1:0]   count_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        pos_q, start_q;
	logic                 act_q;
	slot_t                key_q, hand_q;
	logic                 res_found_q;
	status_t              res_status_q;
	logic                 out_valid_q, out_found_q;
	status_t              out_status_q;
	logic [COUNT_W-1:0]   out_count_q;

	logic [AW-1:0]        mask, home, pos_nxt;
	slot_t                in_key, slot;
	logic                 accept, is_full, slot_empty, slot_match, closer, wrap;
	logic                 swap, probe_done, res_found;
	logic [DIST_W-1:0]    d_nxt;
	status_t              res_status;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	slot_t                ram_wdata, ram_rdata;
	logic                 resp_go;

	rhis_ram #(
		.WIDTH($bits(slot_t)),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A table size above the RAM depth leaves every address bit in the mask.
	always_comb begin
		for (int i = 0; i < AW; i++) begin
			mask[i] = SIZE_W'(i) < size_log2_q;
		end
	end

	always_comb begin
		in_key.w0    = id_word0;
		in_key.mid   = id_mid;
		in_key.top   = id_top;
		in_key.pdist = '0;
		if (id_word0 == '0 && id_mid == '0 && id_top == '0) begin
			in_key.w0 = W0_W'(1);
		end
		home    = in_key.w0[AW-1:0] & mask;
		accept  = in_valid && in_ready;
		is_full = action == ACT_INSERT && count_q >= max_entries_q;
	end

	// Evaluation of the slot read in the previous cycle.
	always_comb begin
		slot       = ram_rdata;
		slot_empty = slot.w0 == '0 && slot.mid == '0 && slot.top == '0;
		slot_match = slot.w0 == key_q.w0 && slot.mid == key_q.mid
			&& slot.top == key_q.top;
		closer     = slot.pdist < hand_q.pdist;
		pos_nxt    = (pos_q + AW'(1)) & mask;
		wrap       = pos_nxt == start_q;
		swap       = act_q == ACT_INSERT && !slot_empty && !slot_match && closer;
		if (swap) begin
			d_nxt = (slot.pdist == DIST_MAX) ? slot.pdist : slot.pdist + DIST_W'(1);
		end else begin
			d_nxt = (hand_q.pdist == DIST_MAX) ? hand_q.pdist
				: hand_q.pdist + DIST_W'(1);
		end
		res_found  = 1'b0;
		res_status = STAT_OK;
		if (act_q == ACT_LOOKUP) begin
			res_found  = slot_match;
			probe_done = slot_match || closer || slot_empty || wrap;
		end else begin
			probe_done = slot_empty || slot_match || wrap;
			priority if (slot_empty) begin
				res_status = STAT_OK;
			end else if (slot_match) begin
				res_status = STAT_DUP;
			end else begin
				res_status = STAT_NOSLOT;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_q) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nxt = is_full ? ST_RESP : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (probe_done) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				if (resp_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		cfg_ready = 1'b1;
		resp_go   = state_q == ST_RESP && (!out_valid_q || out_ready);
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = hand_q;
		ram_re    = 1'b0;
		ram_raddr = pos_nxt;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_re    = accept && !is_full;
				ram_raddr = home;
			end
			ST_PROBE: begin
				ram_we = act_q == ACT_INSERT && (slot_empty || swap);
				ram_re = !probe_done;
			end
			ST_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			size_log2_q   <= SIZE_LOG2_RST;
			max_entries_q <= MAX_ENTRIES_RST;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SIZE_LOG2:   size_log2_q   <= cfg_data[SIZE_W-1:0];
					CFG_MAX_ENTRIES: max_entries_q <= cfg_data[MAXE_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_PROBE && act_q == ACT_INSERT && slot_empty
					&& count_q != COUNT_MAX) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (resp_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q        <= action;
			key_q        <= in_key;
			hand_q       <= in_key;
			pos_q        <= home;
			start_q      <= home;
			res_found_q  <= 1'b0;
			res_status_q <= STAT_FULL;
		end
		if (state_q == ST_PROBE) begin
			// The entry taken out of a richer slot moves on in hand.
			if (swap) begin
				hand_q.w0  <= slot.w0;
				hand_q.mid <= slot.mid;
				hand_q.top <= slot.top;
			end
			hand_q.pdist <= d_nxt;
			pos_q        <= pos_nxt;
			res_found_q  <= res_found;
			res_status_q <= res_status;
		end
		if (resp_go) begin
			out_found_q  <= res_found_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign status     = out_status_q;
	assign used_count = out_count_q;

	`RHIS_ASSERT_NOW(a_rw_apart, ram_we && ram_re, ram_waddr != ram_raddr,
		"read and write collide")
	`RHIS_ASSERT_NEXT(a_lookup_count, state_q == ST_PROBE && act_q == ACT_LOOKUP,
		$stable(count_q), "lookup changed count")
	`RHIS_ASSERT_NOW(a_clear_quiet, state_q == ST_CLEAR, !out_valid_q && !ram_re,
		"activity during clear")
	`RHIS_ASSERT_NEXT(a_resp_out, resp_go,
		out_valid_q && out_status_q == $past(res_status_q), "result not moved out")

endmodule
`default_nettype wire

>>> hw/rtl/rhis_ram.sv
`default_nettype none
module rhis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
